// File: hw/rtl/bmce_pkg.sv
// ----------------------------------------------------------------------------
// bmce_pkg
// Shared types and constants for the boundary max-cut enumerator.
// ----------------------------------------------------------------------------
package bmce_pkg;

    localparam int MAX_VERTICES_DEF = 12;
    localparam int MAX_EDGES_DEF    = 128;
    localparam int MAX_EXTERNAL     = 7;

    localparam int VTX_W    = 4;
    localparam int VTX_SPAN = 2 ** VTX_W;
    localparam int MASK_W   = 6;
    localparam int CUT_W    = 8;
    localparam int NV_CFG_W = 4;
    localparam int NE_CFG_W = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [NV_CFG_W-1:0] NV_RESET = NV_CFG_W'(4);
    localparam logic [NE_CFG_W-1:0] NE_RESET = NE_CFG_W'(3);

    localparam logic REG_IDX_NUM_VERTICES = 1'b0;
    localparam logic REG_IDX_NUM_EXTERNAL = 1'b1;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic             edge_valid;
        logic             last_edge;
    } bmce_req_t;

    typedef struct packed {
        logic [MASK_W-1:0] boundary_mask;
        logic [CUT_W-1:0]  max_cut;
        logic              last_result;
    } bmce_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_READ,
        ST_ACC,
        ST_EMIT
    } bmce_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic rd;
        logic acc;
        logic emit;
    } bmce_cmd_t;

    typedef struct packed {
        logic no_edges;
        logic last_idx;
        logic last_rem;
        logic last_mask;
    } bmce_status_t;

endpackage

// File: hw/rtl/bmce_ctrl.sv
// ----------------------------------------------------------------------------
// bmce_ctrl
// Sequencer that walks masks, internal colorings and stored edges.
// ----------------------------------------------------------------------------
module bmce_ctrl
    import bmce_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         last_edge,
    input  bmce_status_t status,
    output bmce_cmd_t    cmd,
    output logic         busy
);

    bmce_state_t state_reg;
    bmce_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && last_edge)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = status.no_edges ? ST_EMIT : ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (status.last_idx && status.last_rem)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (status.last_mask)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = status.no_edges ? ST_EMIT : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hw/rtl/bmce_datapath.sv
// ----------------------------------------------------------------------------
// bmce_datapath
// Edge memory, loop counters and the cut accumulator with running maximum.
// ----------------------------------------------------------------------------
module bmce_datapath
    import bmce_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [NV_CFG_W-1:0] cfg_nv,
    input  logic [NE_CFG_W-1:0] cfg_ne,
    input  bmce_req_t           req,
    input  bmce_cmd_t           cmd,
    output bmce_status_t        status,
    output logic                result_valid,
    output bmce_result_t        result
);

    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NV_W   = $clog2(MAX_VERTICES + 1);
    localparam int REM_W  = MAX_VERTICES;

    logic [2*VTX_W-1:0] mem [MAX_EDGES];
    logic [2*VTX_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [ADDR_W-1:0]   idx_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_max_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [MASK_W-1:0]   mask_max_reg;
    logic [CNT_W-1:0]    cut_reg;
    logic [CNT_W-1:0]    best_reg;
    logic [NV_W-1:0]     nv_reg;
    logic [NE_CFG_W-1:0] ne_reg;

    logic [NV_W-1:0]     nv_eff;
    logic [NE_CFG_W-1:0] ne_clip;
    logic [NE_CFG_W-1:0] ne_eff;
    logic [NV_W-1:0]     rem_bits;
    logic [REM_W:0]      rem_span;
    logic [MASK_W:0]     mask_span;
    logic [MASK_W-1:0]   mask_max;

    logic                store_ok;
    logic [VTX_W-1:0]    va;
    logic [VTX_W-1:0]    vb;
    logic                a_ok;
    logic                b_ok;
    logic [VTX_SPAN-1:0] colour;
    logic                contrib;
    logic [CNT_W-1:0]    cut_sum;
    logic [CNT_W-1:0]    best_new;

    assign store_ok = req.edge_valid && (count_reg < CNT_W'(MAX_EDGES));

    always_comb
    begin
        if ((NV_W + NV_CFG_W)'(cfg_nv) > (NV_W + NV_CFG_W)'(MAX_VERTICES))
        begin
            nv_eff = NV_W'(MAX_VERTICES);
        end
        else
        begin
            nv_eff = NV_W'(cfg_nv);
        end
        if (32'(cfg_ne) > 32'(MAX_EXTERNAL))
        begin
            ne_clip = NE_CFG_W'(MAX_EXTERNAL);
        end
        else
        begin
            ne_clip = cfg_ne;
        end
        if ((NV_W + NE_CFG_W)'(ne_clip) > (NV_W + NE_CFG_W)'(nv_eff))
        begin
            ne_eff = NE_CFG_W'(nv_eff);
        end
        else
        begin
            ne_eff = ne_clip;
        end
        rem_bits  = nv_eff - NV_W'(ne_eff);
        rem_span  = (REM_W + 1)'(1) << rem_bits;
        mask_span = (MASK_W + 1)'(1) << (ne_eff - NE_CFG_W'(1));
        mask_max  = (ne_eff == '0) ? '0 : MASK_W'(mask_span - (MASK_W + 1)'(1));
    end

    assign va      = rd_data_reg[VTX_W-1:0];
    assign vb      = rd_data_reg[2*VTX_W-1:VTX_W];
    assign a_ok    = (NV_W + VTX_W)'(va) < (NV_W + VTX_W)'(nv_reg);
    assign b_ok    = (NV_W + VTX_W)'(vb) < (NV_W + VTX_W)'(nv_reg);
    assign colour  = VTX_SPAN'(mask_reg) | (VTX_SPAN'(rem_reg) << ne_reg);
    assign contrib = a_ok && b_ok && (colour[va] ^ colour[vb]);
    assign cut_sum = cut_reg + CNT_W'(contrib);
    assign best_new = (cut_sum > best_reg) ? cut_sum : best_reg;

    assign status.no_edges  = (count_reg == '0);
    assign status.last_idx  = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    assign status.last_rem  = (rem_reg == rem_max_reg);
    assign status.last_mask = (mask_reg == mask_max_reg);

    assign result_valid         = cmd.emit;
    assign result.boundary_mask = mask_reg;
    assign result.max_cut       = CUT_W'(best_reg);
    assign result.last_result   = status.last_mask;

    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {req.vertex_b, req.vertex_a};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load && store_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.emit && status.last_mask)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            nv_reg       <= nv_eff;
            ne_reg       <= ne_eff;
            rem_max_reg  <= REM_W'(rem_span - (REM_W + 1)'(1));
            mask_max_reg <= mask_max;
            idx_reg      <= '0;
            rem_reg      <= '0;
            mask_reg     <= '0;
            cut_reg      <= '0;
            best_reg     <= '0;
        end
        else if (cmd.acc)
        begin
            if (status.last_idx)
            begin
                best_reg <= best_new;
                cut_reg  <= '0;
                idx_reg  <= '0;
                if (!status.last_rem)
                begin
                    rem_reg <= rem_reg + REM_W'(1);
                end
            end
            else
            begin
                cut_reg <= cut_sum;
                idx_reg <= idx_reg + ADDR_W'(1);
            end
        end
        else if (cmd.emit)
        begin
            mask_reg <= mask_reg + MASK_W'(1);
            rem_reg  <= '0;
            best_reg <= '0;
            cut_reg  <= '0;
            idx_reg  <= '0;
        end
    end

endmodule

// File: hw/rtl/boundary_max_cut_enumerator_unit.sv
// ----------------------------------------------------------------------------
// boundary_max_cut_enumerator_unit
// Loads a graph edge by edge and reports the maximum cut for each boundary
// coloring of the external vertices in which the highest one is colored 0.
// ----------------------------------------------------------------------------
// Edges are taken one request per cycle while busy is low; a request without
// the last mark gives no result.
// A run passes a prepare state, then for every mask and internal coloring reads
// each stored edge from memory and accumulates it, then emits the mask's result.
// Results come one per mask, one cycle each; the receiver cannot stall them.
// Reset clears the edge count and sets num_vertices to 4 and num_external to 3.
module boundary_max_cut_enumerator_unit
    import bmce_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bmce_req_t          req,
    output logic               result_valid,
    output bmce_result_t       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [NV_CFG_W-1:0] cfg_nv_reg;
    logic [NE_CFG_W-1:0] cfg_ne_reg;
    logic                reg_sel;
    logic                wr_en;
    bmce_cmd_t           cmd;
    bmce_status_t        status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_nv_reg <= NV_RESET;
            cfg_ne_reg <= NE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_IDX_NUM_VERTICES: cfg_nv_reg <= pwdata[NV_CFG_W-1:0];
                REG_IDX_NUM_EXTERNAL: cfg_ne_reg <= pwdata[NE_CFG_W-1:0];
                default:              cfg_nv_reg <= cfg_nv_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_IDX_NUM_VERTICES: prdata = PDATA_W'(cfg_nv_reg);
            REG_IDX_NUM_EXTERNAL: prdata = PDATA_W'(cfg_ne_reg);
            default:              prdata = '0;
        endcase
    end

    bmce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_edge (req.last_edge),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    bmce_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_nv       (cfg_nv_reg),
        .cfg_ne       (cfg_ne_reg),
        .req          (req),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    a_result_only_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n) result_valid |-> busy)
        else $error("Result strobe outside a run.");

    a_last_result_ends_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |=> !busy)
        else $error("Run did not end after its final result.");

    a_more_results_follow: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |=> busy)
        else $error("Run ended before its final result.");

    a_plain_request_stays_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        start && !busy && !req.last_edge |=> !busy && !result_valid)
        else $error("Request without the last mark started a run.");

endmodule
